// ===== rtl/ppc_relocation_word_patch_core_assert.svh =====
// Assertion macros shared by the relocation word patch checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PPC_RELOCATION_WORD_PATCH_CORE_ASSERT_SVH
`define PPC_RELOCATION_WORD_PATCH_CORE_ASSERT_SVH

// The consequent must hold whenever the antecedent is seen out of reset.
`define PPCRWP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion lbl failed");

// The condition must never be seen out of reset.
`define PPCRWP_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion lbl failed");

`endif

// ===== rtl/ppcrwp_pkg.sv =====
// Package for the PowerPC relocation word patch block.
// Holds the item and result types and the fixed codes; no dependencies.
package ppcrwp_pkg;

  // Relocation kinds as carried in the input item.
  typedef enum logic [2:0] {
    KIND_PLAIN = 3'd0,
    KIND_HI16  = 3'd1,
    KIND_LO16  = 3'd2,
    KIND_HA16  = 3'd3,
    KIND_LO14  = 3'd4,
    KIND_BR14  = 3'd5,
    KIND_BR24  = 3'd6,
    KIND_LAZY  = 3'd7
  } reloc_kind_t;

  // Size codes of the plain kind.
  localparam logic [1:0] LEN_BYTE = 2'd0;
  localparam logic [1:0] LEN_HALF = 2'd1;
  localparam logic [1:0] LEN_WORD = 2'd2;

  // Operation codes.
  localparam logic OP_APPLY = 1'b0;
  localparam logic OP_UNDO  = 1'b1;

  // Conditional branch encoding used by the prediction bit fix.
  localparam logic [5:0]  OPC_BC      = 6'd16;
  localparam logic [4:0]  BO_ALWAYS   = 5'b10100;
  localparam logic [31:0] HINT_MASK   = 32'h0020_0000;

  // One relocation entry to patch.
  typedef struct packed {
    logic               op;
    reloc_kind_t        kind;
    logic [1:0]         length_code;
    logic [31:0]        stored_word;
    logic signed [31:0] addend;
    logic [15:0]        paired_half;
    logic               hint_fix;
  } item_t;

  // The patched result of one entry.
  typedef struct packed {
    logic [31:0] new_word;
    logic [15:0] new_paired_half;
    logic        paired_half_valid;
    logic        overflow;
    logic        misaligned;
  } result_t;

endpackage

// ===== rtl/ppcrwp_calc.sv =====
// Combinational patch logic: computes the new word, other half and flags.
// Depends on ppcrwp_pkg for the item and result types.
module ppcrwp_calc (
  input  ppcrwp_pkg::item_t   item,
  output ppcrwp_pkg::result_t res
);

  logic [31:0] w;
  logic [15:0] ph;
  logic [31:0] delta;
  logic [31:0] sum_b, sum_h, sum_w;
  logic [31:0] imm_hi, imm_lo, imm_ha, imm_l14, imm_b14, imm_b24;
  logic [15:0] ha_top;
  logic [31:0] b14_word;
  logic        b14_flip;

  assign w  = item.stored_word;
  assign ph = item.paired_half;

  // Undo subtracts the addend, apply adds it.
  assign delta = (item.op == ppcrwp_pkg::OP_UNDO) ? (32'd0 - $unsigned(item.addend))
                                                  : $unsigned(item.addend);

  // Separate adders for each plain size and each immediate kind; the kind selects among them below.
  assign sum_b   = {{24{w[7]}}, w[7:0]} + delta;
  assign sum_h   = {{16{w[15]}}, w[15:0]} + delta;
  assign sum_w   = w + delta;
  assign imm_hi  = {w[15:0], ph} + delta;
  assign imm_lo  = {ph, w[15:0]} + delta;
  assign imm_ha  = {w[15:0], 16'h0000} + {{16{ph[15]}}, ph} + delta;
  assign imm_l14 = {ph, w[15:2], 2'b00} + delta;
  assign imm_b14 = {{16{w[15]}}, w[15:2], 2'b00} + delta;
  assign imm_b24 = {{6{w[25]}}, w[25:2], 2'b00} + delta;

  // High-adjusted half rounds up when the low half is negative.
  assign ha_top = imm_ha[31:16] + {15'd0, imm_ha[15]};

  // A conditional branch whose displacement changes sign gets its hint flipped.
  assign b14_word = {w[31:16], imm_b14[15:2], w[1:0]};
  assign b14_flip = item.hint_fix && (w[31:26] == ppcrwp_pkg::OPC_BC) &&
                    (w[25:21] != ppcrwp_pkg::BO_ALWAYS) && (b14_word[15] != w[15]);

  // Select the result for the kind.
  always_comb begin
    res = '0;
    res.new_word = w;
    unique case (item.kind)
      ppcrwp_pkg::KIND_PLAIN: begin
        case (item.length_code)
          ppcrwp_pkg::LEN_BYTE: begin
            res.new_word = {24'd0, sum_b[7:0]};
            res.overflow = (|sum_b[31:8]) && !(&sum_b[31:7]);
          end
          ppcrwp_pkg::LEN_HALF: begin
            res.new_word = {16'd0, sum_h[15:0]};
            res.overflow = (|sum_h[31:16]) && !(&sum_h[31:15]);
          end
          ppcrwp_pkg::LEN_WORD: res.new_word = sum_w;
          default: res.new_word = w;
        endcase
      end
      ppcrwp_pkg::KIND_HI16: begin
        res.new_word          = {w[31:16], imm_hi[31:16]};
        res.new_paired_half   = imm_hi[15:0];
        res.paired_half_valid = item.op;
      end
      ppcrwp_pkg::KIND_LO16: begin
        res.new_word          = {w[31:16], imm_lo[15:0]};
        res.new_paired_half   = imm_lo[31:16];
        res.paired_half_valid = item.op;
      end
      ppcrwp_pkg::KIND_HA16: begin
        res.new_word          = {w[31:16], ha_top};
        res.new_paired_half   = imm_ha[15:0];
        res.paired_half_valid = item.op;
      end
      ppcrwp_pkg::KIND_LO14: begin
        res.new_word          = {w[31:16], imm_l14[15:2], w[1:0]};
        res.new_paired_half   = imm_l14[31:16];
        res.paired_half_valid = item.op;
        res.misaligned        = |imm_l14[1:0];
      end
      ppcrwp_pkg::KIND_BR14: begin
        res.new_word   = b14_flip ? (b14_word ^ ppcrwp_pkg::HINT_MASK) : b14_word;
        res.misaligned = |imm_b14[1:0];
        res.overflow   = (|imm_b14[31:17]) && !(&imm_b14[31:17]);
      end
      ppcrwp_pkg::KIND_BR24: begin
        res.new_word   = {w[31:26], imm_b24[25:2], w[1:0]};
        res.misaligned = |imm_b24[1:0];
        res.overflow   = (|imm_b24[31:25]) && !(&imm_b24[31:25]);
      end
      ppcrwp_pkg::KIND_LAZY: res.new_word = $unsigned(item.addend);
      default: res.new_word = w;
    endcase
    // The other half is only reported when it must be written back.
    if (!res.paired_half_valid) begin
      res.new_paired_half = '0;
    end
  end

endmodule

// ===== rtl/ppc_relocation_word_patch_core.sv =====
// Top level of the PowerPC relocation word patch block.
// Depends on ppcrwp_pkg and ppcrwp_calc.
//
// Usage:
//   Input channel: drive the in_ fields and raise start; an entry transfers
//   at a rising edge where start is high and busy is low. Out of reset busy
//   stays low, so one entry may transfer every cycle.
//   Result channel: out_valid is high for exactly one cycle with the patched
//   word, the other half and its write-back flag, and the overflow and
//   misalignment flags. The receiver takes it at the edge ending that cycle
//   and cannot hold it off.
//   Pipeline: an accepted entry is held in the input register, patched, and
//   held in the result register that drives the outputs. Throughput: one entry
//   per cycle, set by the single input register, patch logic and result
//   register path. Reset: synchronous, active low. It clears the valid bits of
//   both stages and the ready bit; busy is high during reset and until ready
//   is set after it. No configuration; no stored state but these registers.
module ppc_relocation_word_patch_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic [2:0]         in_reloc_kind,
  input  logic [1:0]         in_length_code,
  input  logic [31:0]        in_stored_word,
  input  logic signed [31:0] in_addend,
  input  logic [15:0]        in_paired_half,
  input  logic               in_hint_fix,
  output logic               out_valid,
  output logic [31:0]        out_new_word,
  output logic [15:0]        out_new_paired_half,
  output logic               out_paired_half_valid,
  output logic               out_overflow,
  output logic               out_misaligned
);

  logic                rdy_r;
  logic                accept;
  logic                item_valid_r;
  ppcrwp_pkg::item_t   item_r, item_nxt;
  ppcrwp_pkg::result_t res_comb;
  ppcrwp_pkg::result_t res_r;
  logic                res_valid_r;

  assign busy   = !rdy_r;
  assign accept = start && rdy_r;

  // Ready is registered and comes up in the cycle after reset is released.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdy_r <= 1'b0;
    end else begin
      rdy_r <= 1'b1;
    end
  end

  // Pack the input ports into one item.
  always_comb begin
    item_nxt.op          = in_op;
    item_nxt.kind        = ppcrwp_pkg::reloc_kind_t'(in_reloc_kind);
    item_nxt.length_code = in_length_code;
    item_nxt.stored_word = in_stored_word;
    item_nxt.addend      = in_addend;
    item_nxt.paired_half = in_paired_half;
    item_nxt.hint_fix    = in_hint_fix;
  end

  // Input register stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  ppcrwp_calc u_calc (
    .item (item_r),
    .res  (res_comb)
  );

  // Result register stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid_r) begin
      res_r <= res_comb;
    end
  end

  assign out_valid             = res_valid_r;
  assign out_new_word          = res_r.new_word;
  assign out_new_paired_half   = res_r.new_paired_half;
  assign out_paired_half_valid = res_r.paired_half_valid;
  assign out_overflow          = res_r.overflow;
  assign out_misaligned        = res_r.misaligned;

endmodule

// ===== rtl/ppcrwp_checker.sv =====
// Port-level checker for the relocation word patch block, bound to its top.
// Depends on ppc_relocation_word_patch_core_assert.svh for the macros.
`include "ppc_relocation_word_patch_core_assert.svh"

module ppcrwp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_op,
  input logic        out_valid,
  input logic [15:0] out_new_paired_half,
  input logic        out_paired_half_valid,
  input logic        out_overflow
);

  // Every transfer in produces a result once it has passed both register stages.
  `PPCRWP_ASSERT_IMPL(a_result_follows, start && !busy, ##2 out_valid)

  // No result appears without a transfer in that has passed both register stages.
  `PPCRWP_ASSERT_IMPL(a_no_invented, out_valid, $past(start && !busy, 2))

  // A written-back other half only comes from an undo.
  `PPCRWP_ASSERT_IMPL(a_pair_from_undo, out_valid && out_paired_half_valid, $past(in_op, 2))

  // Paired kinds never flag overflow, and an unused other half reads zero.
  `PPCRWP_ASSERT_NEVER(a_pair_no_ovf, out_valid && out_paired_half_valid && out_overflow)
  `PPCRWP_ASSERT_NEVER(a_pair_zero,
    out_valid && !out_paired_half_valid && (out_new_paired_half != 16'd0))

endmodule

bind ppc_relocation_word_patch_core ppcrwp_checker u_ppcrwp_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .start                 (start),
  .busy                  (busy),
  .in_op                 (in_op),
  .out_valid             (out_valid),
  .out_new_paired_half   (out_new_paired_half),
  .out_paired_half_valid (out_paired_half_valid),
  .out_overflow          (out_overflow)
);

// ===== tb/tb_ppc_relocation_word_patch_core.sv =====
// Self-checking testbench for ppc_relocation_word_patch_core.
// Depends on ppcrwp_pkg; drives directed and random relocation entries and
// checks every patched word against a built-in prediction of the patch.
module tb_ppc_relocation_word_patch_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ENTRIES = 2000;
  localparam int CALM_TAIL      = 300;
  localparam int DRAIN_CYCLES   = 8;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_op = 1'b0;
  logic [2:0]         in_reloc_kind = '0;
  logic [1:0]         in_length_code = '0;
  logic [31:0]        in_stored_word = '0;
  logic signed [31:0] in_addend = '0;
  logic [15:0]        in_paired_half = '0;
  logic               in_hint_fix = 1'b0;
  logic               out_valid;
  logic [31:0]        out_new_word;
  logic [15:0]        out_new_paired_half;
  logic               out_paired_half_valid;
  logic               out_overflow;
  logic               out_misaligned;

  // Entries waiting to be sent and patches waiting to come back.
  ppcrwp_pkg::item_t   pending_entries[$];
  ppcrwp_pkg::result_t expected_patches[$];
  ppcrwp_pkg::item_t   cur_entry;
  bit                  have_entry = 1'b0;
  int                  gap_left = 0;
  int                  mismatch_count = 0;
  int                  quiet_cycles = 0;

  ppc_relocation_word_patch_core DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_op                 (in_op),
    .in_reloc_kind         (in_reloc_kind),
    .in_length_code        (in_length_code),
    .in_stored_word        (in_stored_word),
    .in_addend             (in_addend),
    .in_paired_half        (in_paired_half),
    .in_hint_fix           (in_hint_fix),
    .out_valid             (out_valid),
    .out_new_word          (out_new_word),
    .out_new_paired_half   (out_new_paired_half),
    .out_paired_half_valid (out_paired_half_valid),
    .out_overflow          (out_overflow),
    .out_misaligned        (out_misaligned)
  );

  // Free-running clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Computes the patched word, the rewritten other half and the flags of one entry.
  function automatic ppcrwp_pkg::result_t predict_patch(ppcrwp_pkg::item_t it);
    logic [31:0]         word;
    logic [31:0]         delta;
    logic [31:0]         imm;
    logic [31:0]         rounded;
    logic [31:0]         res;
    logic [15:0]         pair;
    logic                pvalid;
    logic                ovf;
    logic                mis;
    logic                sign;
    ppcrwp_pkg::result_t r;
    word   = it.stored_word;
    delta  = (it.op == ppcrwp_pkg::OP_UNDO) ? 32'd0 - it.addend : it.addend;
    res    = word;
    pair   = '0;
    pvalid = 1'b0;
    ovf    = 1'b0;
    mis    = 1'b0;
    case (it.kind)
      ppcrwp_pkg::KIND_PLAIN: begin
        // Byte and halfword are sign-extended, added and range-checked.
        if (it.length_code == ppcrwp_pkg::LEN_BYTE) begin
          imm = {{24{word[7]}}, word[7:0]} + delta;
          ovf = (imm[31:8] != '0) && (imm[31:7] != '1);
          res = {24'd0, imm[7:0]};
        end else if (it.length_code == ppcrwp_pkg::LEN_HALF) begin
          imm = {{16{word[15]}}, word[15:0]} + delta;
          ovf = (imm[31:16] != '0) && (imm[31:15] != '1);
          res = {16'd0, imm[15:0]};
        end else if (it.length_code == ppcrwp_pkg::LEN_WORD) begin
          res = word + delta;
        end
      end
      ppcrwp_pkg::KIND_HI16: begin
        imm    = {word[15:0], it.paired_half} + delta;
        res    = {word[31:16], imm[31:16]};
        pair   = imm[15:0];
        pvalid = it.op;
      end
      ppcrwp_pkg::KIND_LO16: begin
        imm    = {it.paired_half, word[15:0]} + delta;
        res    = {word[31:16], imm[15:0]};
        pair   = imm[31:16];
        pvalid = it.op;
      end
      ppcrwp_pkg::KIND_HA16: begin
        // The low half is sign-extended; a set bit 15 rounds the high half up.
        imm     = {word[15:0], 16'd0} + {{16{it.paired_half[15]}}, it.paired_half} + delta;
        rounded = imm[15] ? imm + 32'h0000_8000 : imm;
        res     = {word[31:16], rounded[31:16]};
        pair    = imm[15:0];
        pvalid  = it.op;
      end
      ppcrwp_pkg::KIND_LO14: begin
        imm    = {it.paired_half, word[15:2], 2'b00} + delta;
        mis    = (imm[1:0] != 2'b00);
        res    = {word[31:16], imm[15:2], word[1:0]};
        pair   = imm[31:16];
        pvalid = it.op;
      end
      ppcrwp_pkg::KIND_BR14: begin
        sign = word[15];
        imm  = {{16{word[15]}}, word[15:2], 2'b00} + delta;
        mis  = (imm[1:0] != 2'b00);
        ovf  = (imm[31:17] != '0) && (imm[31:17] != '1);
        res  = {word[31:16], imm[15:2], word[1:0]};
        // Conditional branches get the prediction bit flipped on a sign change.
        if (it.hint_fix && res[31:26] == ppcrwp_pkg::OPC_BC &&
            res[25:21] != ppcrwp_pkg::BO_ALWAYS && res[15] != sign) begin
          res = res ^ ppcrwp_pkg::HINT_MASK;
        end
      end
      ppcrwp_pkg::KIND_BR24: begin
        imm = {{6{word[25]}}, word[25:2], 2'b00} + delta;
        mis = (imm[1:0] != 2'b00);
        ovf = (imm[31:25] != '0) && (imm[31:25] != '1);
        res = {word[31:26], imm[25:2], word[1:0]};
      end
      default: begin
        res = it.addend;
      end
    endcase
    if (!pvalid) begin
      pair = '0;
    end
    r.new_word          = res;
    r.new_paired_half   = pair;
    r.paired_half_valid = pvalid;
    r.overflow          = ovf;
    r.misaligned        = mis;
    return r;
  endfunction

  function automatic ppcrwp_pkg::item_t make_entry(logic op, ppcrwp_pkg::reloc_kind_t kind,
                                                   logic [1:0] len, logic [31:0] word,
                                                   logic [31:0] addend, logic [15:0] half,
                                                   logic hint);
    ppcrwp_pkg::item_t it;
    it.op          = op;
    it.kind        = kind;
    it.length_code = len;
    it.stored_word = word;
    it.addend      = addend;
    it.paired_half = half;
    it.hint_fix    = hint;
    return it;
  endfunction

  // Random entry; addends lean toward small values and word multiples so that
  // the range and alignment checks see both outcomes.
  function automatic ppcrwp_pkg::item_t random_entry();
    ppcrwp_pkg::item_t it;
    logic [31:0]       word;
    int                sel;
    it.op          = 1'($urandom_range(0, 1));
    it.kind        = ppcrwp_pkg::reloc_kind_t'($urandom_range(0, 7));
    it.length_code = 2'($urandom_range(0, 3));
    word = $urandom();
    if (it.kind == ppcrwp_pkg::KIND_BR14 && $urandom_range(0, 1) == 1) begin
      word[31:26] = ppcrwp_pkg::OPC_BC;
      if ($urandom_range(0, 3) == 0) begin
        word[25:21] = ppcrwp_pkg::BO_ALWAYS;
      end
    end
    it.stored_word = word;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      it.addend = int'($urandom_range(0, 1024)) - 512;
    end else if (sel < 6) begin
      it.addend = (int'($urandom_range(0, 8192)) - 4096) * 4;
    end else if (sel == 6) begin
      case ($urandom_range(0, 3))
        0: it.addend = 32'h8000_0000;
        1: it.addend = 32'h7fff_ffff;
        2: it.addend = 32'hffff_ffff;
        default: it.addend = 32'h0000_0000;
      endcase
    end else begin
      it.addend = $urandom();
    end
    it.paired_half = 16'($urandom());
    it.hint_fix    = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic drive_fields(ppcrwp_pkg::item_t it);
    in_op          <= it.op;
    in_reloc_kind  <= it.kind;
    in_length_code <= it.length_code;
    in_stored_word <= it.stored_word;
    in_addend      <= it.addend;
    in_paired_half <= it.paired_half;
    in_hint_fix    <= it.hint_fix;
  endtask

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", fname, want, got);
      mismatch_count++;
    end
  endtask

  // Driver: records each input transfer and presents the next entry, with
  // random idle bursts while enough entries remain.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      have_entry = 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        expected_patches.push_back(predict_patch(cur_entry));
        have_entry = 1'b0;
      end
      if (!have_entry) begin
        if (gap_left == 0 && pending_entries.size() > CALM_TAIL &&
            $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 15);
        end
        if (gap_left > 0) begin
          gap_left--;
          drive_fields(random_entry());
        end else if (pending_entries.size() > 0) begin
          cur_entry = pending_entries.pop_front();
          have_entry = 1'b1;
          drive_fields(cur_entry);
        end
      end
      start <= have_entry;
    end
  end

  // Monitor: each result transfer is matched against the oldest expected patch.
  always @(posedge clk) begin
    ppcrwp_pkg::result_t want;
    if (rst_n && out_valid) begin
      if (expected_patches.size() == 0) begin
        $error("result transfer with no patch expected: new_word 0x%0h", out_new_word);
        mismatch_count++;
      end else begin
        want = expected_patches.pop_front();
        check_field("new_word", want.new_word, out_new_word);
        check_field("new_paired_half", want.new_paired_half, out_new_paired_half);
        check_field("paired_half_valid", want.paired_half_valid, out_paired_half_valid);
        check_field("overflow", want.overflow, out_overflow);
        check_field("misaligned", want.misaligned, out_misaligned);
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus: directed entries, a full drain, then random entries.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Plain sizes at their range limits, word wraparound and the unused size code.
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_APPLY, ppcrwp_pkg::KIND_PLAIN,
                                         ppcrwp_pkg::LEN_BYTE,
                                         32'h0000_007f, 32'd1, 16'h0000, 1'b0));
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_UNDO, ppcrwp_pkg::KIND_PLAIN,
                                         ppcrwp_pkg::LEN_BYTE,
                                         32'hffff_ff80, 32'd1, 16'hffff, 1'b1));
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_APPLY, ppcrwp_pkg::KIND_PLAIN,
                                         ppcrwp_pkg::LEN_HALF,
                                         32'h0000_7fff, 32'd1, 16'h0000, 1'b0));
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_UNDO, ppcrwp_pkg::KIND_PLAIN,
                                         ppcrwp_pkg::LEN_HALF,
                                         32'h1234_8000, 32'hffff_ffff, 16'h0000, 1'b0));
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_APPLY, ppcrwp_pkg::KIND_PLAIN,
                                         ppcrwp_pkg::LEN_WORD,
                                         32'hffff_ffff, 32'h7fff_ffff, 16'h0000, 1'b0));
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_UNDO, ppcrwp_pkg::KIND_PLAIN,
                                         ppcrwp_pkg::LEN_WORD,
                                         32'h0000_0000, 32'h8000_0000, 16'h0000, 1'b0));
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_APPLY, ppcrwp_pkg::KIND_PLAIN, 2'd3,
                                         32'hdead_beef, 32'h0000_1000, 16'h0000, 1'b0));
    // Paired halves, applied and undone, with the high-adjust carry and a negative low half.
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_APPLY, ppcrwp_pkg::KIND_HI16,
                                         ppcrwp_pkg::LEN_WORD,
                                         32'h3c60_1234, 32'h0001_8000, 16'h9000, 1'b0));
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_UNDO, ppcrwp_pkg::KIND_HI16,
                                         ppcrwp_pkg::LEN_BYTE,
                                         32'h3c60_0000, 32'h0000_0001, 16'h0000, 1'b0));
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_UNDO, ppcrwp_pkg::KIND_LO16,
                                         ppcrwp_pkg::LEN_HALF,
                                         32'h3863_ffff, 32'hffff_ffff, 16'hffff, 1'b0));
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_APPLY, ppcrwp_pkg::KIND_HA16,
                                         ppcrwp_pkg::LEN_WORD,
                                         32'h3c60_0001, 32'h0000_0000, 16'h8000, 1'b0));
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_UNDO, ppcrwp_pkg::KIND_HA16,
                                         ppcrwp_pkg::LEN_WORD,
                                         32'h3c60_0010, 32'hffff_8000, 16'h7fff, 1'b0));
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_APPLY, ppcrwp_pkg::KIND_HA16,
                                         ppcrwp_pkg::LEN_WORD,
                                         32'h3c60_0000, 32'h0000_8000, 16'h0000, 1'b0));
    // Low fourteen bits, aligned undo and a misaligned apply.
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_UNDO, ppcrwp_pkg::KIND_LO14,
                                         ppcrwp_pkg::LEN_WORD,
                                         32'he863_0102, 32'h0001_0004, 16'h0002, 1'b0));
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_APPLY, ppcrwp_pkg::KIND_LO14,
                                         ppcrwp_pkg::LEN_WORD,
                                         32'he863_fffd, 32'h0000_0002, 16'hffff, 1'b0));
    // Conditional branch: prediction bit flip, no flip for branch-always,
    // a displacement that wraps past the top of the field and a misaligned target.
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_APPLY, ppcrwp_pkg::KIND_BR14,
                                         ppcrwp_pkg::LEN_WORD,
                                         32'h4080_0010, 32'hffff_ffe0, 16'h0000, 1'b1));
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_APPLY, ppcrwp_pkg::KIND_BR14,
                                         ppcrwp_pkg::LEN_WORD,
                                         32'h4280_0010, 32'hffff_ffe0, 16'h0000, 1'b1));
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_UNDO, ppcrwp_pkg::KIND_BR14,
                                         ppcrwp_pkg::LEN_WORD,
                                         32'h4080_0010, 32'hffff_ffe0, 16'h0000, 1'b0));
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_APPLY, ppcrwp_pkg::KIND_BR14,
                                         ppcrwp_pkg::LEN_WORD,
                                         32'h4180_7ffc, 32'h0000_0004, 16'h0000, 1'b1));
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_APPLY, ppcrwp_pkg::KIND_BR14,
                                         ppcrwp_pkg::LEN_WORD,
                                         32'h4180_0000, 32'h0000_0001, 16'h0000, 1'b0));
    // Unconditional branch: overflow both ways and misalignment.
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_APPLY, ppcrwp_pkg::KIND_BR24,
                                         ppcrwp_pkg::LEN_WORD,
                                         32'h49ff_fffd, 32'h0000_0004, 16'h0000, 1'b0));
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_UNDO, ppcrwp_pkg::KIND_BR24,
                                         ppcrwp_pkg::LEN_WORD,
                                         32'h4a00_0001, 32'h0000_0004, 16'h0000, 1'b0));
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_APPLY, ppcrwp_pkg::KIND_BR24,
                                         ppcrwp_pkg::LEN_WORD,
                                         32'h4800_0000, 32'h0000_0006, 16'h0000, 1'b0));
    // Lazy pointer takes the addend whatever the operation.
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_UNDO, ppcrwp_pkg::KIND_LAZY,
                                         ppcrwp_pkg::LEN_BYTE,
                                         32'hffff_ffff, 32'h8000_0000, 16'hffff, 1'b1));
    pending_entries.push_back(make_entry(ppcrwp_pkg::OP_APPLY, ppcrwp_pkg::KIND_LAZY,
                                         ppcrwp_pkg::LEN_WORD,
                                         32'h0000_0000, 32'h7fff_ffff, 16'h0000, 1'b0));

    // Hold off until every directed patch has come back.
    while (pending_entries.size() != 0 || have_entry || expected_patches.size() != 0) begin
      @(posedge clk);
    end

    for (int i = 0; i < RANDOM_ENTRIES; i++) begin
      pending_entries.push_back(random_entry());
    end

    while (pending_entries.size() != 0 || have_entry || expected_patches.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
